### sv/gfhp_pkg.sv
package gfhp_pkg;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FORMAT = 3'd1;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_BAD_LAYOUT = 3'd4;
    localparam logic [2:0] ST_BAD_COMPR  = 3'd5;

    localparam logic [31:0] MIN_HDR_LEN = 32'd20;
    localparam logic [1:0]  COMPR_MAX   = 2'd2;
    localparam logic [3:0]  LAYOUT_V1   = 4'd1;
    localparam logic [3:0]  LAYOUT_V2   = 4'd2;
    localparam int          SAMPLE_ID_BIT = 31;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_offset;
        logic [31:0] header_size;
        logic [31:0] variant_count;
        logic [31:0] sample_count;
        logic [1:0]  compression_mode;
        logic [3:0]  layout_version;
        logic        sample_ids_present;
        logic        magic_was_zero;
    } t_result;

    // Expected text magic, one character per position.
    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h62;
            2'd1: c = 8'h67;
            2'd2: c = 8'h65;
            default: c = 8'h6E;
        endcase
        return c;
    endfunction

endpackage

### sv/genotype_file_header_parser.sv
// Genotype file header parser.
// Input channel: one file byte per word on i_data_byte, with i_end_of_stream
// marking the end of the file and i_restart starting a new file with this word.
// A word is taken on a rising edge with i_in_valid high and o_in_stall low.
// Output channel: at most one result per file (status, the four header words,
// the decoded flags and the magic kind), taken with o_out_valid high and
// i_out_stall low.
// Throughput: one word per cycle while o_in_stall is low. A word is held in
// the input register, is parsed by the header state logic, and its result is
// loaded into the output register, which drives o_out_valid. The skip of extra
// header bytes is a down counter, one byte per cycle while o_in_stall is low.
// When a result waits and the receiver stalls, the input register holds one
// more word and o_in_stall rises; o_in_stall follows i_out_stall in the same
// cycle. Synchronous reset (i_rst_n low) empties both registers and returns
// the parser to the start of a file.
module genotype_file_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_header_size,
    output logic [31:0] o_variant_count,
    output logic [31:0] o_sample_count,
    output logic [1:0]  o_compression_mode,
    output logic [3:0]  o_layout_version,
    output logic        o_sample_ids_present,
    output logic        o_magic_was_zero
);

    logic              r_in_valid;
    logic [7:0]        r_byte;
    logic              r_eos;
    logic              r_restart;
    logic              r_out_valid;
    gfhp_pkg::t_result r_res;

    logic              move;
    logic              step;
    logic              accept;
    logic              res_valid;
    gfhp_pkg::t_result res;

    assign move       = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && move;
    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;

    gfhp_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_data_byte     (r_byte),
        .i_end_of_stream (r_eos),
        .i_restart       (r_restart),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end

            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on handshake, hold otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte    <= i_data_byte;
            r_eos     <= i_end_of_stream;
            r_restart <= i_restart;
        end
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_res.status;
    assign o_data_offset        = r_res.data_offset;
    assign o_header_size        = r_res.header_size;
    assign o_variant_count      = r_res.variant_count;
    assign o_sample_count       = r_res.sample_count;
    assign o_compression_mode   = r_res.compression_mode;
    assign o_layout_version     = r_res.layout_version;
    assign o_sample_ids_present = r_res.sample_ids_present;
    assign o_magic_was_zero     = r_res.magic_was_zero;

endmodule

### sv/gfhp_parse.sv
module gfhp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_stream,
    input  logic              i_restart,
    output logic              o_res_valid,
    output gfhp_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_WORDS,
        PH_MAGIC,
        PH_EXTRA,
        PH_FLAGS,
        PH_DONE
    } t_phase;

    t_phase      r_phase, c_phase, n_phase;
    logic [3:0]  r_idx, c_idx, n_idx;
    logic [31:0] r_skip, n_skip;
    logic [31:0] r_offset, c_offset, n_offset;
    logic [31:0] r_length, c_length, n_length;
    logic [31:0] r_variants, c_variants, n_variants;
    logic [31:0] r_samples, c_samples, n_samples;
    logic [31:0] r_flags, c_flags, n_flags;
    logic        r_text_ok, c_text_ok, n_text_ok;
    logic        r_zero_ok, c_zero_ok, n_zero_ok;

    logic        emit;
    logic        magic_seen;
    logic [2:0]  status;
    logic [4:0]  bit_base;
    logic [3:0]  layout;
    logic [1:0]  compr;

    // A restart item sees the parser in its reset state.
    always_comb begin
        if (i_restart) begin
            c_phase    = PH_WORDS;
            c_idx      = '0;
            c_offset   = '0;
            c_length   = '0;
            c_variants = '0;
            c_samples  = '0;
            c_flags    = '0;
            c_text_ok  = 1'b1;
            c_zero_ok  = 1'b1;
        end else begin
            c_phase    = r_phase;
            c_idx      = r_idx;
            c_offset   = r_offset;
            c_length   = r_length;
            c_variants = r_variants;
            c_samples  = r_samples;
            c_flags    = r_flags;
            c_text_ok  = r_text_ok;
            c_zero_ok  = r_zero_ok;
        end
    end

    always_comb begin
        n_phase    = c_phase;
        n_idx      = c_idx;
        n_skip     = r_skip;
        n_offset   = c_offset;
        n_length   = c_length;
        n_variants = c_variants;
        n_samples  = c_samples;
        n_flags    = c_flags;
        n_text_ok  = c_text_ok;
        n_zero_ok  = c_zero_ok;
        emit       = 1'b0;
        magic_seen = 1'b1;
        status     = gfhp_pkg::ST_OK;
        bit_base   = {c_idx[1:0], 3'b000};
        layout     = '0;
        compr      = '0;

        if (c_phase != PH_DONE && i_end_of_stream) begin
            emit = 1'b1;
            if (c_phase == PH_WORDS || c_phase == PH_MAGIC) begin
                status     = gfhp_pkg::ST_NOT_FORMAT;
                magic_seen = 1'b0;
            end else begin
                status = gfhp_pkg::ST_TRUNCATED;
            end
        end else begin
            unique case (c_phase)
                PH_WORDS: begin
                    unique case (c_idx[3:2])
                        2'd0: n_offset[bit_base +: 8]   = i_data_byte;
                        2'd1: n_length[bit_base +: 8]   = i_data_byte;
                        2'd2: n_variants[bit_base +: 8] = i_data_byte;
                        default: n_samples[bit_base +: 8] = i_data_byte;
                    endcase
                    n_idx = c_idx + 4'd1;
                    if (c_idx == 4'd15) begin
                        n_phase = PH_MAGIC;
                    end
                end
                PH_MAGIC: begin
                    n_text_ok = c_text_ok && (i_data_byte == gfhp_pkg::magic_char(c_idx[1:0]));
                    n_zero_ok = c_zero_ok && (i_data_byte == 8'd0);
                    n_idx     = c_idx + 4'd1;
                    if (c_idx[1:0] == 2'd3) begin
                        n_idx = '0;
                        if (!n_text_ok && !n_zero_ok) begin
                            emit   = 1'b1;
                            status = gfhp_pkg::ST_NOT_FORMAT;
                        end else if (c_length < gfhp_pkg::MIN_HDR_LEN
                                     || c_length > c_offset) begin
                            emit   = 1'b1;
                            status = gfhp_pkg::ST_BAD_LENGTH;
                        end else if (c_length == gfhp_pkg::MIN_HDR_LEN) begin
                            n_phase = PH_FLAGS;
                        end else begin
                            n_phase = PH_EXTRA;
                            n_skip  = c_length - gfhp_pkg::MIN_HDR_LEN;
                        end
                    end
                end
                PH_EXTRA: begin
                    // count down the extra header bytes, drop their contents
                    if (r_skip == 32'd1) begin
                        n_phase = PH_FLAGS;
                    end else begin
                        n_skip = r_skip - 32'd1;
                    end
                end
                PH_FLAGS: begin
                    n_flags[bit_base +: 8] = i_data_byte;
                    n_idx = c_idx + 4'd1;
                    if (c_idx[1:0] == 2'd3) begin
                        n_idx  = '0;
                        emit   = 1'b1;
                        layout = n_flags[5:2];
                        compr  = n_flags[1:0];
                        if (layout != gfhp_pkg::LAYOUT_V1 && layout != gfhp_pkg::LAYOUT_V2) begin
                            status = gfhp_pkg::ST_BAD_LAYOUT;
                        end else if (compr > gfhp_pkg::COMPR_MAX) begin
                            status = gfhp_pkg::ST_BAD_COMPR;
                        end else begin
                            status = gfhp_pkg::ST_OK;
                        end
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        if (emit) begin
            n_phase = PH_DONE;
        end
    end

    assign o_res_valid                = i_step && emit;
    assign o_res.status               = status;
    assign o_res.data_offset          = n_offset;
    assign o_res.header_size          = n_length;
    assign o_res.variant_count        = n_variants;
    assign o_res.sample_count         = n_samples;
    assign o_res.compression_mode     = n_flags[1:0];
    assign o_res.layout_version       = n_flags[5:2];
    assign o_res.sample_ids_present   = n_flags[gfhp_pkg::SAMPLE_ID_BIT];
    assign o_res.magic_was_zero       = magic_seen && n_zero_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WORDS;
            r_idx      <= '0;
            r_skip     <= '0;
            r_offset   <= '0;
            r_length   <= '0;
            r_variants <= '0;
            r_samples  <= '0;
            r_flags    <= '0;
            r_text_ok  <= 1'b1;
            r_zero_ok  <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_skip     <= n_skip;
            r_offset   <= n_offset;
            r_length   <= n_length;
            r_variants <= n_variants;
            r_samples  <= n_samples;
            r_flags    <= n_flags;
            r_text_ok  <= n_text_ok;
            r_zero_ok  <= n_zero_ok;
        end
    end

endmodule

### sim/genotype_file_header_parser_checker.sv
`timescale 1ns / 1ps
module genotype_file_header_parser_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_stream,
    input  logic              i_restart,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  gfhp_pkg::t_result i_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_consumed
);

    typedef enum logic [2:0] {
        HDR_WORDS,
        HDR_MAGIC,
        HDR_EXTRA,
        HDR_FLAGS,
        HDR_DONE
    } t_hdr_phase;

    localparam logic [31:0] MAGIC_TEXT   = "bgen";
    localparam int          REPORT_LIMIT = 10;
    localparam int          NUM_FIELDS   = 9;

    t_hdr_phase        hdr_phase;
    logic [31:0]       byte_cnt;
    logic [31:0]       offset_w;
    logic [31:0]       length_w;
    logic [31:0]       variants_w;
    logic [31:0]       samples_w;
    logic [31:0]       flags_w;
    logic              text_ok;
    logic              zero_ok;
    gfhp_pkg::t_result header_results[$];

    task automatic clear_parse();
        hdr_phase  = HDR_WORDS;
        byte_cnt   = '0;
        offset_w   = '0;
        length_w   = '0;
        variants_w = '0;
        samples_w  = '0;
        flags_w    = '0;
        text_ok    = 1'b1;
        zero_ok    = 1'b1;
    endtask

    function automatic gfhp_pkg::t_result pack_result(input logic [2:0] st);
        gfhp_pkg::t_result r;
        r.status             = st;
        r.data_offset        = offset_w;
        r.header_size        = length_w;
        r.variant_count      = variants_w;
        r.sample_count       = samples_w;
        r.compression_mode   = flags_w[1:0];
        r.layout_version     = flags_w[5:2];
        r.sample_ids_present = flags_w[gfhp_pkg::SAMPLE_ID_BIT];
        // magic kind only counts once all four magic bytes went through
        r.magic_was_zero     = zero_ok && hdr_phase != HDR_WORDS && hdr_phase != HDR_MAGIC;
        return r;
    endfunction

    task automatic parse_word(input logic [7:0] b, input logic eos, input logic rs,
                              output logic fired, output gfhp_pkg::t_result res);
        logic [4:0] sh;
        logic [1:0] mpos;
        logic [3:0] layout;
        fired = 1'b0;
        res   = '0;
        if (rs) begin
            clear_parse();
        end
        sh    = {byte_cnt[1:0], 3'b000};
        mpos  = 2'd3 - byte_cnt[1:0];
        if (hdr_phase == HDR_DONE) begin
            return;
        end
        o_consumed++;
        if (eos) begin
            fired = 1'b1;
            res = pack_result((hdr_phase == HDR_WORDS || hdr_phase == HDR_MAGIC)
                              ? gfhp_pkg::ST_NOT_FORMAT : gfhp_pkg::ST_TRUNCATED);
            hdr_phase = HDR_DONE;
            return;
        end
        case (hdr_phase)
            HDR_WORDS: begin
                case (byte_cnt[3:2])
                    2'd0:    offset_w   |= 32'(b) << sh;
                    2'd1:    length_w   |= 32'(b) << sh;
                    2'd2:    variants_w |= 32'(b) << sh;
                    default: samples_w  |= 32'(b) << sh;
                endcase
                if (byte_cnt == 32'd15) begin
                    byte_cnt  = '0;
                    hdr_phase = HDR_MAGIC;
                end else begin
                    byte_cnt++;
                end
            end
            HDR_MAGIC: begin
                if (b != MAGIC_TEXT[{mpos, 3'b000} +: 8]) text_ok = 1'b0;
                if (b != 8'd0) zero_ok = 1'b0;
                if (byte_cnt[1:0] != 2'd3) begin
                    byte_cnt++;
                end else begin
                    byte_cnt  = '0;
                    hdr_phase = HDR_EXTRA;
                    if (!text_ok && !zero_ok) begin
                        fired = 1'b1;
                        res   = pack_result(gfhp_pkg::ST_NOT_FORMAT);
                        hdr_phase = HDR_DONE;
                    end else if (length_w < gfhp_pkg::MIN_HDR_LEN
                                 || length_w > offset_w) begin
                        fired = 1'b1;
                        res   = pack_result(gfhp_pkg::ST_BAD_LENGTH);
                        hdr_phase = HDR_DONE;
                    end else if (length_w == gfhp_pkg::MIN_HDR_LEN) begin
                        hdr_phase = HDR_FLAGS;
                    end
                end
            end
            HDR_EXTRA: begin
                byte_cnt++;
                if (byte_cnt >= length_w - gfhp_pkg::MIN_HDR_LEN) begin
                    byte_cnt  = '0;
                    hdr_phase = HDR_FLAGS;
                end
            end
            default: begin
                flags_w |= 32'(b) << sh;
                if (byte_cnt[1:0] != 2'd3) begin
                    byte_cnt++;
                end else begin
                    byte_cnt  = '0;
                    hdr_phase = HDR_DONE;
                    layout    = flags_w[5:2];
                    fired     = 1'b1;
                    // layout is judged before compression
                    if (layout != gfhp_pkg::LAYOUT_V1 && layout != gfhp_pkg::LAYOUT_V2) begin
                        res = pack_result(gfhp_pkg::ST_BAD_LAYOUT);
                    end else if (flags_w[1:0] > gfhp_pkg::COMPR_MAX) begin
                        res = pack_result(gfhp_pkg::ST_BAD_COMPR);
                    end else begin
                        res = pack_result(gfhp_pkg::ST_OK);
                    end
                end
            end
        endcase
    endtask

    function automatic logic [31:0] field_of(input gfhp_pkg::t_result r, input int k);
        case (k)
            0:       return 32'(r.status);
            1:       return r.data_offset;
            2:       return r.header_size;
            3:       return r.variant_count;
            4:       return r.sample_count;
            5:       return 32'(r.compression_mode);
            6:       return 32'(r.layout_version);
            7:       return 32'(r.sample_ids_present);
            default: return 32'(r.magic_was_zero);
        endcase
    endfunction

    function automatic string field_name(input int k);
        case (k)
            0:       return "status";
            1:       return "data_offset";
            2:       return "header_size";
            3:       return "variant_count";
            4:       return "sample_count";
            5:       return "compression_mode";
            6:       return "layout_version";
            7:       return "sample_ids_present";
            default: return "magic_was_zero";
        endcase
    endfunction

    task automatic log_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : p_watch
        gfhp_pkg::t_result want;
        gfhp_pkg::t_result got;
        logic              fired;
        int                k;
        if (!i_rst_n) begin
            clear_parse();
            header_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_consumed   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (header_results.size() == 0) begin
                    log_failure($sformatf("result with nothing expected, status %0d",
                                          i_result.status));
                end else begin
                    want = header_results.pop_front();
                    o_checked++;
                    for (k = 0; k < NUM_FIELDS; k++) begin
                        if (field_of(i_result, k) !== field_of(want, k)) begin
                            log_failure($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                                                  o_checked, field_name(k),
                                                  field_of(want, k), field_of(i_result, k)));
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_word(i_data_byte, i_end_of_stream, i_restart, fired, got);
                if (fired) header_results.push_back(got);
            end
        end
        o_pending = header_results.size();
    end

endmodule

### sim/genotype_file_header_parser_tb.sv
`timescale 1ns / 1ps
module genotype_file_header_parser_tb;

    localparam int          RANDOM_ITEMS   = 1050;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          LONG_HOLD      = 64;
    localparam int          TAIL_CYCLES    = 8;
    localparam logic [31:0] MAGIC_TEXT     = "bgen";

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic [7:0]        i_data_byte     = 8'd0;
    logic              i_end_of_stream = 1'b0;
    logic              i_restart       = 1'b0;
    logic              i_out_stall     = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [2:0]        o_status;
    logic [31:0]       o_data_offset;
    logic [31:0]       o_header_size;
    logic [31:0]       o_variant_count;
    logic [31:0]       o_sample_count;
    logic [1:0]        o_compression_mode;
    logic [3:0]        o_layout_version;
    logic              o_sample_ids_present;
    logic              o_magic_was_zero;
    gfhp_pkg::t_result dut_result;

    int          fail_count;
    int          pending;
    int          checked;
    int          consumed;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          files_sent     = 0;
    logic        hold_req       = 1'b0;
    logic [7:0]  file_bytes[$];

    genotype_file_header_parser u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_data_byte          (i_data_byte),
        .i_end_of_stream      (i_end_of_stream),
        .i_restart            (i_restart),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_data_offset        (o_data_offset),
        .o_header_size        (o_header_size),
        .o_variant_count      (o_variant_count),
        .o_sample_count       (o_sample_count),
        .o_compression_mode   (o_compression_mode),
        .o_layout_version     (o_layout_version),
        .o_sample_ids_present (o_sample_ids_present),
        .o_magic_was_zero     (o_magic_was_zero)
    );

    assign dut_result = {o_status, o_data_offset, o_header_size, o_variant_count,
                         o_sample_count, o_compression_mode, o_layout_version,
                         o_sample_ids_present, o_magic_was_zero};

    genotype_file_header_parser_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_restart       (i_restart),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_result        (dut_result),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_consumed      (consumed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("genotype_file_header_parser_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stall, plus one long hold-off on request
    initial begin : p_sink
        int k;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                for (k = 0; k < LONG_HOLD; k++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end
            i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [31:0] mk_flags(input logic sid, input logic [3:0] layout,
                                             input logic [1:0] compr);
        return {sid, 25'd0, layout, compr};
    endfunction

    task automatic build_header(input logic [31:0] off, input logic [31:0] len,
                                input logic [31:0] nvar, input logic [31:0] nsamp,
                                input logic [31:0] magic, input int extra,
                                input logic [31:0] flags);
        logic [127:0] words;
        int k;
        file_bytes.delete();
        words = {nsamp, nvar, len, off};
        for (k = 0; k < 16; k++) file_bytes.push_back(words[8*k +: 8]);
        for (k = 3; k >= 0; k--) file_bytes.push_back(magic[8*k +: 8]);
        repeat (extra) file_bytes.push_back(8'($urandom));
        for (k = 0; k < 4; k++) file_bytes.push_back(flags[8*k +: 8]);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] b, input logic eos, input logic rs);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= eos;
        i_restart       <= rs;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_file(input int cut, input logic with_eos);
        int k;
        for (k = 0; k < cut; k++) send_word(file_bytes[k], 1'b0, k == 0);
        if (with_eos) send_word(8'($urandom), 1'b1, cut == 0);
        files_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    initial begin : p_stim
        int          mode;
        int          base;
        int          kind;
        int          extra;
        int          cut;
        logic        eos_flag;
        logic [31:0] off;
        logic [31:0] len;
        logic [31:0] magic;
        logic [31:0] flags;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // end of stream on the very first word, with restart
        send_word(8'hA5, 1'b1, 1'b1);
        build_header(32'd20, 32'd20, 32'd1, 32'd1, MAGIC_TEXT, 0,
                     mk_flags(1'b1, gfhp_pkg::LAYOUT_V1, 2'd0));
        send_file(file_bytes.size(), 1'b0);
        build_header(32'hFFFF_FFFF, 32'd24, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 4,
                     mk_flags(1'b0, gfhp_pkg::LAYOUT_V2, gfhp_pkg::COMPR_MAX));
        send_file(file_bytes.size(), 1'b0);
        build_header(32'd100, 32'd20, 32'd3, 32'd4, "bgex", 0,
                     mk_flags(1'b0, gfhp_pkg::LAYOUT_V1, 2'd1));
        send_file(file_bytes.size(), 1'b0);
        // header length below the minimum, then above the offset
        build_header(32'd100, 32'd19, 32'd3, 32'd4, 32'd0, 0,
                     mk_flags(1'b0, gfhp_pkg::LAYOUT_V1, 2'd1));
        send_file(file_bytes.size(), 1'b0);
        build_header(32'd30, 32'd31, 32'd3, 32'd4, MAGIC_TEXT, 2,
                     mk_flags(1'b0, gfhp_pkg::LAYOUT_V1, 2'd1));
        send_file(file_bytes.size(), 1'b0);
        build_header(32'd40, 32'd20, 32'd5, 32'd6, MAGIC_TEXT, 0, mk_flags(1'b1, 4'd0, 2'd0));
        send_file(file_bytes.size(), 1'b0);
        build_header(32'd40, 32'd20, 32'd5, 32'd6, 32'd0, 0, mk_flags(1'b0, 4'hF, 2'd3));
        send_file(file_bytes.size(), 1'b0);
        build_header(32'd40, 32'd20, 32'd5, 32'd6, MAGIC_TEXT, 0,
                     mk_flags(1'b1, gfhp_pkg::LAYOUT_V1, 2'd3));
        send_file(file_bytes.size(), 1'b0);
        // early end in the fixed words, the magic, the extra bytes and the flags
        build_header(32'h1234_5678, 32'd26, 32'd7, 32'd8, 32'd0, 6,
                     mk_flags(1'b0, gfhp_pkg::LAYOUT_V2, 2'd0));
        send_file(5, 1'b1);
        send_file(18, 1'b1);
        send_file(22, 1'b1);
        build_header(32'd20, 32'd20, 32'd7, 32'd8, MAGIC_TEXT, 0, 32'h8000_00C9);
        send_file(22, 1'b1);
        send_file(20, 1'b1);
        // words after the result are dropped until restart
        send_file(file_bytes.size(), 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        // restart in the middle of a file
        send_file(10, 1'b0);
        send_file(file_bytes.size(), 1'b0);

        base = consumed;
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                    hold_req       = 1'b1;
                end
                1: begin
                    send_gap_pct   = 55;
                    recv_stall_pct = 0;
                end
                2: begin
                    drain();
                    send_gap_pct   = 0;
                    recv_stall_pct = 55;
                end
                default: begin
                    send_gap_pct   = 27;
                    recv_stall_pct = 27;
                end
            endcase
            while (consumed - base < (mode + 1) * RANDOM_ITEMS / 4) begin
                kind  = $urandom_range(99);
                len   = gfhp_pkg::MIN_HDR_LEN + (($urandom_range(3) == 0) ? $urandom_range(20)
                                                                           : $urandom_range(2));
                off   = $urandom;
                if (off < len) off = len + $urandom_range(64);
                magic = $urandom_range(1) ? MAGIC_TEXT : 32'd0;
                flags = $urandom;
                flags[5:2] = $urandom_range(1) ? gfhp_pkg::LAYOUT_V1 : gfhp_pkg::LAYOUT_V2;
                flags[1:0] = 2'($urandom_range(2));
                if (kind < 12) begin
                    flags = $urandom;
                end else if (kind < 18) begin
                    magic ^= 32'd1 << $urandom_range(31);
                end else if (kind < 24) begin
                    if ($urandom_range(1)) begin
                        len = $urandom_range(gfhp_pkg::MIN_HDR_LEN - 1);
                    end else begin
                        len = $urandom_range(32'hFFFF_FFFF, gfhp_pkg::MIN_HDR_LEN + 1);
                        off = $urandom_range(len - 1);
                    end
                end
                extra = (len >= gfhp_pkg::MIN_HDR_LEN && len <= off)
                        ? int'(len - gfhp_pkg::MIN_HDR_LEN) : 2;
                build_header(off, len, $urandom, $urandom, magic, extra, flags);
                cut      = file_bytes.size();
                eos_flag = 1'b0;
                if (kind >= 85) begin
                    cut      = $urandom_range(file_bytes.size() - 1);
                    eos_flag = $urandom_range(3) != 0;
                end
                send_file(cut, eos_flag);
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(3, 1)) begin
                        send_word(8'($urandom), 1'($urandom_range(1)), 1'b0);
                    end
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("covered %0d files, %0d parsed words and %0d header results", files_sent,
                 consumed, checked);
        $display("idle mixes: none, sender gaps, receiver stalls, both; %0d left unmatched",
                 pending);
        if (fail_count == 0 && pending == 0) begin
            $display("genotype_file_header_parser_tb: done, clean");
        end else begin
            $display("genotype_file_header_parser_tb: done, errors");
        end
        $finish;
    end

endmodule
